FILE: rtl/packet_host_statistics_unit_assert.svh
// ----------------------------------------------------------------------------
// packet_host_statistics_unit_assert
// Assertion macros for the host statistics unit.
// ----------------------------------------------------------------------------
`ifndef PACKET_HOST_STATISTICS_UNIT_ASSERT_SVH
`define PACKET_HOST_STATISTICS_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PHS_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PHS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/phs_pkg.sv
// ----------------------------------------------------------------------------
// phs_pkg
// Types, codes and constants shared by the host statistics unit.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int HOST_ENTRIES_DEF = 64;
  localparam int PORT_ENTRIES_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam logic [7:0]  LEN_ADJ_RESET = 8'd16;
  localparam logic [15:0] KIND_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  typedef enum logic [2:0] {
    CMD_PACKET   = 3'd0,
    CMD_RD_SEND  = 3'd1,
    CMD_RD_RECV  = 3'd2,
    CMD_RD_SPORT = 3'd3,
    CMD_RD_DPORT = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] frame_length;
    logic [47:0] time_us;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ether_kind;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
    logic [5:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] packet_total;
    logic [15:0] min_length;
    logic [15:0] max_length;
    logic [47:0] byte_total;
    logic [47:0] duration_us;
    logic        overflow;
    logic        entry_valid;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
    logic [31:0] entry_packets;
    logic [15:0] entry_port;
  } out_word_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        is_packet;
    logic        rd_send;
    logic        rd_recv;
    logic        rd_sport;
    logic        rd_dport;
    logic        is_ipv4;
    logic        is_udp;
    logic [15:0] adj_len;
    logic [47:0] time_us;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [5:0]  read_index;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_READ,
    ST_READ_WAIT,
    ST_OUT
  } bk_state_t;

endpackage

FILE: rtl/packet_host_statistics_unit.sv
// ----------------------------------------------------------------------------
// packet_host_statistics_unit
// Per-host packet counter with bounded MAC tables and UDP port sets.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | word
// in_     | in  | in_valid/stall   | in_word_t, one command or packet
// out_    | out | out_valid/stall  | out_word_t, one result per word
// cfg_    | in  | cfg_valid/ready  | length_adjust, 8 bits
//
// A packet's search runs to the last used entry of the fullest table: the back
// end scans all four tables one entry a cycle through each memory's single
// read port. A read command passes ST_READ and ST_READ_WAIT. No clearing pass
// after reset. Reset is synchronous, active low. A two-word queue parts front
// and back; the output register holds the result while out_stall is high.
module packet_host_statistics_unit #(
  parameter int HOST_ENTRIES = phs_pkg::HOST_ENTRIES_DEF,
  parameter int PORT_ENTRIES = phs_pkg::PORT_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  phs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output phs_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import phs_pkg::*;

  logic       cfg_wr;
  logic [7:0] adj_r;
  logic       job_valid, job_ready, busy;
  job_t       job;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) adj_r <= LEN_ADJ_RESET;
    else if (cfg_wr) adj_r <= cfg_data;
  end

  phs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .len_adj(adj_r), .job_valid, .job_ready, .job
  );

  phs_back #(.HOST_ENTRIES(HOST_ENTRIES), .PORT_ENTRIES(PORT_ENTRIES)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid, .out_stall, .out_data, .busy
  );

`include "packet_host_statistics_unit_assert.svh"

  `PHS_ASSERT_IMP(a_idle_no_out, clk, rst_n, !busy, !out_valid)
  `PHS_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid)
  `PHS_ASSERT_IMP(a_entry_zero, clk, rst_n, out_valid && !out_data.entry_valid,
                  out_data.entry_mac == '0 && out_data.entry_port == '0)

endmodule

FILE: rtl/phs_front.sv
// ----------------------------------------------------------------------------
// phs_front
// Accepts input words, decodes the command and computes the adjusted length.
// ----------------------------------------------------------------------------
module phs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  phs_pkg::in_word_t in_data,
  input  logic [7:0]        len_adj,
  output logic              job_valid,
  input  logic              job_ready,
  output phs_pkg::job_t     job
);
  import phs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t            q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  job_t            cls;
  logic            push, pop;

  // classify the incoming word
  always_comb begin
    cls = '0;
    cls.is_packet  = (in_data.command == CMD_PACKET);
    cls.rd_send    = (in_data.command == CMD_RD_SEND);
    cls.rd_recv    = (in_data.command == CMD_RD_RECV);
    cls.rd_sport   = (in_data.command == CMD_RD_SPORT);
    cls.rd_dport   = (in_data.command == CMD_RD_DPORT);
    cls.is_ipv4    = (in_data.ether_kind == KIND_IPV4);
    cls.is_udp     = (in_data.ip_protocol == PROTO_UDP);
    cls.adj_len    = (in_data.frame_length > {8'd0, len_adj}) ?
                     in_data.frame_length - {8'd0, len_adj} : 16'd0;
    cls.time_us    = in_data.time_us;
    cls.src_mac    = in_data.src_mac;
    cls.dst_mac    = in_data.dst_mac;
    cls.ip_source  = in_data.ip_source;
    cls.ip_dest    = in_data.ip_dest;
    cls.sport      = in_data.udp_source_port;
    cls.dport      = in_data.udp_dest_port;
    cls.read_index = in_data.read_index;
  end

  assign in_stall  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = push ? PW'((wp_r + 1'b1) % QUEUE_DEPTH) : wp_r;
    rp_nxt  = pop  ? PW'((rp_r + 1'b1) % QUEUE_DEPTH) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

FILE: rtl/phs_back.sv
// ----------------------------------------------------------------------------
// phs_back
// Searches the host tables and port sets one entry a cycle, updates them and
// the running statistics, and serves read commands.
// ----------------------------------------------------------------------------
module phs_back #(
  parameter int HOST_ENTRIES = phs_pkg::HOST_ENTRIES_DEF,
  parameter int PORT_ENTRIES = phs_pkg::PORT_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  phs_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_stall,
  output phs_pkg::out_word_t out_data,
  output logic               busy
);
  import phs_pkg::*;

  localparam int HW = $clog2(HOST_ENTRIES);
  localparam int PWD = $clog2(PORT_ENTRIES);
  localparam int SW = ((HW > PWD) ? HW : PWD) + 1;
  localparam int RW = (SW > 6) ? SW : 6;

  // table memories: one write and one read port each
  logic [47:0] smac_m [HOST_ENTRIES];
  logic [31:0] sip_m  [HOST_ENTRIES];
  logic [31:0] scnt_m [HOST_ENTRIES];
  logic [47:0] rmac_m [HOST_ENTRIES];
  logic [31:0] rip_m  [HOST_ENTRIES];
  logic [31:0] rcnt_m [HOST_ENTRIES];
  logic [15:0] sp_m   [PORT_ENTRIES];
  logic [15:0] dp_m   [PORT_ENTRIES];

  bk_state_t   st_r, st_nxt;
  job_t        j_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [HW:0]   sused_r, rused_r;
  logic [PWD:0]  spused_r, dpused_r;
  logic [SW-1:0] sused_x, rused_x, spused_x, dpused_x;
  logic          sfound_r, rfound_r, spfound_r, dpfound_r;
  logic [HW-1:0] sslot_r, rslot_r;
  logic [31:0]   scnt_hit_r, rcnt_hit_r;
  logic          rd_ok_r, rd_phase_r;

  // registered read data
  logic [47:0] smac_q, rmac_q;
  logic [31:0] sip_q, scnt_q, rip_q, rcnt_q;
  logic [15:0] sp_q, dp_q;

  logic [31:0] pkt_r;
  logic [15:0] min_r, max_r;
  logic [47:0] sum_r, first_r, last_r;
  logic        full_r;
  out_word_t   o_r, o_nxt;
  logic        ov_r;
  logic        out_load;
  logic        full_hit;

  logic search_done;
  logic [48:0] sum_ext;

  assign sused_x  = SW'(sused_r);
  assign rused_x  = SW'(rused_r);
  assign spused_x = SW'(spused_r);
  assign dpused_x = SW'(dpused_r);

  // search ends when the read pointer has passed every used entry;
  // idx_r is the read address; the compare sees the data registered from idx_r-1
  assign search_done = (idx_r >= sused_x) && (idx_r >= rused_x) &&
                       (idx_r >= spused_x) && (idx_r >= dpused_x);

  assign job_ready = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = o_r;
  assign busy      = (st_r != ST_IDLE) || ov_r;
  assign sum_ext   = {1'b0, sum_r} + {33'd0, j_r.adj_len};
  assign out_load  = (st_r == ST_OUT) && (!ov_r || !out_stall);

  // a new key that finds its table or set full
  assign full_hit = (!sfound_r && sused_r == (HW+1)'(HOST_ENTRIES)) ||
                    (!rfound_r && rused_r == (HW+1)'(HOST_ENTRIES)) ||
                    (j_r.is_ipv4 && j_r.is_udp &&
                     ((!spfound_r && spused_r == (PWD+1)'(PORT_ENTRIES)) ||
                      (!dpfound_r && dpused_r == (PWD+1)'(PORT_ENTRIES))));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (job_valid) st_nxt = job.is_packet ? ST_SEARCH : ST_READ;
      ST_SEARCH:    if (rd_phase_r && search_done) st_nxt = ST_UPDATE;
      ST_UPDATE:    st_nxt = ST_OUT;
      ST_READ:      st_nxt = ST_READ_WAIT;
      ST_READ_WAIT: st_nxt = ST_OUT;
      ST_OUT:       if (!ov_r || !out_stall) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // search index; read commands address the requested entry
  always_comb begin
    idx_nxt = idx_r;
    case (st_r)
      ST_IDLE:   idx_nxt = (job_valid && !job.is_packet) ? SW'(job.read_index) : '0;
      ST_SEARCH: if (rd_phase_r) idx_nxt = idx_r + 1'b1;
      default:   idx_nxt = idx_r;
    endcase
  end

  // memory reads, registered
  always_ff @(posedge clk) begin
    smac_q <= smac_m[idx_r[HW-1:0]];
    scnt_q <= scnt_m[idx_r[HW-1:0]];
    rmac_q <= rmac_m[idx_r[HW-1:0]];
    rcnt_q <= rcnt_m[idx_r[HW-1:0]];
    sp_q   <= sp_m[idx_r[PWD-1:0]];
    dp_q   <= dp_m[idx_r[PWD-1:0]];
    sip_q  <= sip_m[idx_r[HW-1:0]];
    rip_q  <= rip_m[idx_r[HW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      idx_r      <= '0;
      rd_phase_r <= 1'b0;
      sused_r    <= '0;
      rused_r    <= '0;
      spused_r   <= '0;
      dpused_r   <= '0;
      pkt_r      <= '0;
      min_r      <= '1;
      max_r      <= '0;
      sum_r      <= '0;
      first_r    <= '0;
      last_r     <= '0;
      full_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && job_valid) rd_phase_r <= 1'b0;
      else if (st_r == ST_SEARCH) rd_phase_r <= 1'b1;
      if (st_r == ST_SEARCH && !rd_phase_r) idx_r <= '0;
      else idx_r <= idx_nxt;
      ov_r <= out_load || (ov_r && out_stall);
      if (st_r == ST_UPDATE) begin
        if (pkt_r == '0) first_r <= j_r.time_us;
        last_r <= j_r.time_us;
        if (pkt_r != '1) pkt_r <= pkt_r + 1'b1;
        sum_r <= sum_ext[48] ? '1 : sum_ext[47:0];
        if (j_r.adj_len < min_r) min_r <= j_r.adj_len;
        if (j_r.adj_len > max_r) max_r <= j_r.adj_len;
        if (full_hit) full_r <= 1'b1;
        if (!sfound_r && sused_r != (HW+1)'(HOST_ENTRIES)) sused_r <= sused_r + 1'b1;
        if (!rfound_r && rused_r != (HW+1)'(HOST_ENTRIES)) rused_r <= rused_r + 1'b1;
        if (j_r.is_ipv4 && j_r.is_udp) begin
          if (!spfound_r && spused_r != (PWD+1)'(PORT_ENTRIES))
            spused_r <= spused_r + 1'b1;
          if (!dpfound_r && dpused_r != (PWD+1)'(PORT_ENTRIES))
            dpused_r <= dpused_r + 1'b1;
        end
      end
    end
  end

  // search bookkeeping; compare uses registered read data from address idx_r-1
  logic [SW-1:0] cmp_idx;
  assign cmp_idx = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      j_r       <= job;
      sfound_r  <= 1'b0;
      rfound_r  <= 1'b0;
      spfound_r <= 1'b0;
      dpfound_r <= 1'b0;
    end else if (st_r == ST_SEARCH && rd_phase_r && idx_r != '0) begin
      if (!sfound_r && cmp_idx < sused_x && smac_q == j_r.src_mac) begin
        sfound_r   <= 1'b1;
        sslot_r    <= cmp_idx[HW-1:0];
        scnt_hit_r <= scnt_q;
      end
      if (!rfound_r && cmp_idx < rused_x && rmac_q == j_r.dst_mac) begin
        rfound_r   <= 1'b1;
        rslot_r    <= cmp_idx[HW-1:0];
        rcnt_hit_r <= rcnt_q;
      end
      if (cmp_idx < spused_x && sp_q == j_r.sport) spfound_r <= 1'b1;
      if (cmp_idx < dpused_x && dp_q == j_r.dport) dpfound_r <= 1'b1;
    end
  end

  // table writes
  logic [HW-1:0] s_wr, r_wr;
  logic          s_en, r_en;
  assign s_wr = sfound_r ? sslot_r : sused_r[HW-1:0];
  assign r_wr = rfound_r ? rslot_r : rused_r[HW-1:0];
  assign s_en = (st_r == ST_UPDATE) && (sfound_r || sused_r != (HW+1)'(HOST_ENTRIES));
  assign r_en = (st_r == ST_UPDATE) && (rfound_r || rused_r != (HW+1)'(HOST_ENTRIES));

  always_ff @(posedge clk) begin
    if (s_en) begin
      smac_m[s_wr] <= j_r.src_mac;
      scnt_m[s_wr] <= sfound_r ? ((scnt_hit_r == '1) ? scnt_hit_r : scnt_hit_r + 1'b1)
                               : 32'd1;
      if (j_r.is_ipv4) sip_m[s_wr] <= j_r.ip_source;
      else if (!sfound_r) sip_m[s_wr] <= '0;
    end
    if (r_en) begin
      rmac_m[r_wr] <= j_r.dst_mac;
      rcnt_m[r_wr] <= rfound_r ? ((rcnt_hit_r == '1) ? rcnt_hit_r : rcnt_hit_r + 1'b1)
                               : 32'd1;
      if (j_r.is_ipv4) rip_m[r_wr] <= j_r.ip_dest;
      else if (!rfound_r) rip_m[r_wr] <= '0;
    end
    if (st_r == ST_UPDATE && j_r.is_ipv4 && j_r.is_udp) begin
      if (!spfound_r && spused_r != (PWD+1)'(PORT_ENTRIES))
        sp_m[spused_r[PWD-1:0]] <= j_r.sport;
      if (!dpfound_r && dpused_r != (PWD+1)'(PORT_ENTRIES))
        dp_m[dpused_r[PWD-1:0]] <= j_r.dport;
    end
  end

  // read commands reuse the search address for every table
  logic [RW-1:0] ri;
  assign ri = RW'(j_r.read_index);
  always_ff @(posedge clk) begin
    if (st_r == ST_READ) begin
      rd_ok_r <= (j_r.rd_send  && ri < RW'(sused_x) && ri < RW'(HOST_ENTRIES)) ||
                 (j_r.rd_recv  && ri < RW'(rused_x) && ri < RW'(HOST_ENTRIES)) ||
                 (j_r.rd_sport && ri < RW'(spused_x) && ri < RW'(PORT_ENTRIES)) ||
                 (j_r.rd_dport && ri < RW'(dpused_x) && ri < RW'(PORT_ENTRIES));
    end
  end

  // result word
  always_comb begin
    o_nxt              = '0;
    o_nxt.packet_total = pkt_r;
    o_nxt.min_length   = min_r;
    o_nxt.max_length   = max_r;
    o_nxt.byte_total   = sum_r;
    o_nxt.duration_us  = (pkt_r != '0 && last_r >= first_r) ? last_r - first_r : '0;
    o_nxt.overflow     = full_r;
    if (!j_r.is_packet && rd_ok_r) begin
      o_nxt.entry_valid = 1'b1;
      if (j_r.rd_send) begin
        o_nxt.entry_mac     = smac_q;
        o_nxt.entry_ip      = sip_q;
        o_nxt.entry_packets = scnt_q;
      end
      if (j_r.rd_recv) begin
        o_nxt.entry_mac     = rmac_q;
        o_nxt.entry_ip      = rip_q;
        o_nxt.entry_packets = rcnt_q;
      end
      if (j_r.rd_sport) o_nxt.entry_port = sp_q;
      if (j_r.rd_dport) o_nxt.entry_port = dp_q;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) o_r <= o_nxt;
  end

endmodule
